[hw/rtl/ihex_pkg.sv]
// Shared constants, types and helpers for the Intel HEX image loader.
`default_nettype none

package ihex_pkg;

    localparam int ADDR_BITS_DEF  = 16;
    localparam int MAX_RECORD_DEF = 256;

    localparam logic [23:0] TOTAL_MAX = 24'hFFFFFF;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [2:0] {
        ST_BUSY      = 3'd0,
        ST_COMMITTED = 3'd1,
        ST_END       = 3'd2,
        ST_ERROR     = 3'd3,
        ST_OTHER     = 3'd4,
        ST_IGNORED   = 3'd5
    } status_t;

    // request from the line parser to the commit unit
    typedef struct packed {
        logic        start;
        logic [15:0] base;
        logic [7:0]  count;
    } commit_req_t;

    // progress of the commit unit back to the parser
    typedef struct packed {
        logic       done;
        logic [7:0] stage_idx;
    } commit_stat_t;

    // bit 4 set for a hex digit of either case, bits 3..0 its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ihex_commit.sv]
// Commit unit: copies staged record bytes into the image memory and keeps the marks.
`default_nettype none

module ihex_commit
    import ihex_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire commit_req_t          req,
    output      commit_stat_t         stat,
    input  wire logic [7:0]           stage_data,
    input  wire logic                 rd_en,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output      logic [7:0]           rd_data,
    output      logic [ADDR_BITS:0]   low_mark,
    output      logic [ADDR_BITS-1:0] high_mark,
    output      logic [23:0]          byte_total
);

    localparam int IMG_DEPTH = 1 << ADDR_BITS;

    logic [7:0] image_mem [IMG_DEPTH];

    logic                 busy_reg;
    logic [7:0]           idx_reg;
    logic [7:0]           count_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic                 wr_valid_reg;
    logic [ADDR_BITS-1:0] wr_addr_reg;
    logic [7:0]           rd_data_reg;
    logic [ADDR_BITS:0]   low_reg;
    logic [ADDR_BITS-1:0] high_reg;
    logic [23:0]          total_reg;
    logic                 issue;

    assign issue          = busy_reg && (idx_reg != count_reg);
    assign stat.done      = busy_reg && !issue && !wr_valid_reg;
    assign stat.stage_idx = idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            idx_reg      <= 8'd0;
            wr_valid_reg <= 1'b0;
            low_reg      <= (ADDR_BITS+1)'(IMG_DEPTH);
            high_reg     <= '0;
            total_reg    <= 24'd0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg     <= 1'b1;
                idx_reg      <= 8'd0;
                wr_valid_reg <= 1'b0;
            end
            else if (busy_reg)
            begin
                wr_valid_reg <= issue;
                if (issue)
                begin
                    idx_reg <= idx_reg + 8'd1;
                end
                else if (!wr_valid_reg)
                begin
                    busy_reg <= 1'b0;
                end
            end
            // one address per cycle through the compare and count unit
            if (wr_valid_reg)
            begin
                if ({1'b0, wr_addr_reg} < low_reg)
                begin
                    low_reg <= {1'b0, wr_addr_reg};
                end
                if (wr_addr_reg > high_reg)
                begin
                    high_reg <= wr_addr_reg;
                end
                if (total_reg != TOTAL_MAX)
                begin
                    total_reg <= total_reg + 24'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            addr_reg  <= ADDR_BITS'({{ADDR_BITS{1'b0}}, req.base});
            count_reg <= req.count;
        end
        else if (issue)
        begin
            addr_reg <= addr_reg + ADDR_BITS'(1);
        end
        if (issue)
        begin
            wr_addr_reg <= addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid_reg)
        begin
            image_mem[wr_addr_reg] <= stage_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= image_mem[rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign low_mark   = low_reg;
    assign high_mark  = high_reg;
    assign byte_total = total_reg;

endmodule

`default_nettype wire

[hw/rtl/intel_hex_image_loader.sv]
// Intel HEX image loader: line parser, staging buffer and result register.
// A text character passes through the work and send states, and an image read also
// through the read state; a good data line waits at its line end in the commit state
// while the commit unit writes a byte a cycle. No new item is taken until the result
// of the last one is in the output register.
// Reset (rst_n low, asynchronous) clears parser, marks and total; memories are not swept.
`default_nettype none

module intel_hex_image_loader
    import ihex_pkg::*;
#(
    parameter int ADDR_BITS  = ADDR_BITS_DEF,
    parameter int MAX_RECORD = MAX_RECORD_DEF,
    localparam int IN_W      = ((8 + ADDR_BITS + 7) / 8) * 8,
    localparam int OUT_W     = ((2 * ADDR_BITS + 33 + 7) / 8) * 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_axis_tvalid,
    output      logic             s_axis_tready,
    // text_char, read_address
    input  wire logic [IN_W-1:0]  s_axis_tdata,
    // action
    input  wire logic             s_axis_tuser,
    output      logic             m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // read_data, lowest_address, highest_address, bytes_loaded
    output      logic [OUT_W-1:0] m_axis_tdata,
    // status
    output      logic [2:0]       m_axis_tuser
);

    localparam int IDX_W = $clog2(MAX_RECORD);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WORK,
        S_READ,
        S_COMMIT,
        S_SEND
    } state_t;

    typedef enum logic [2:0] {
        PH_START,
        PH_LEN,
        PH_AHI,
        PH_ALO,
        PH_TYPE,
        PH_DATA,
        PH_SUM,
        PH_TRAIL
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic             nib_valid_reg, nib_valid_next;
    logic [3:0]       nib_val_reg, nib_val_next;
    logic [7:0]       len_reg, len_next;
    logic [15:0]      addr_reg, addr_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       sum_reg, sum_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             bad_reg, bad_next;
    logic             done_reg, done_next;

    // held item
    logic                 act_reg;
    logic [7:0]           char_reg;
    logic [ADDR_BITS-1:0] raddr_reg;

    // result and output register
    status_t          res_status_reg, res_status_next;
    logic [7:0]       res_rdata_reg, res_rdata_next;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] out_data_reg, out_data_next;
    status_t          out_user_reg, out_user_next;

    // staging buffer for one record's data bytes
    logic [7:0] staged_mem [MAX_RECORD];
    logic [7:0] stg_rd_reg;
    logic       stg_we;
    logic [7:0] stg_byte;

    commit_req_t          creq;
    commit_stat_t         cstat;
    logic                 rd_en;
    logic [7:0]           rd_data;
    logic [ADDR_BITS:0]   low_mark;
    logic [ADDR_BITS-1:0] high_mark;
    logic [23:0]          byte_total;

    logic       accept;
    logic       out_free;
    logic [4:0] hex;
    logic [7:0] byte_val;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign hex           = hex_digit(char_reg);
    assign byte_val      = {nib_val_reg, hex[3:0]};

    ihex_commit #(
        .ADDR_BITS (ADDR_BITS)
    ) u_commit (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (creq),
        .stat       (cstat),
        .stage_data (stg_rd_reg),
        .rd_en      (rd_en),
        .rd_addr    (raddr_reg),
        .rd_data    (rd_data),
        .low_mark   (low_mark),
        .high_mark  (high_mark),
        .byte_total (byte_total)
    );

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        nib_valid_next  = nib_valid_reg;
        nib_val_next    = nib_val_reg;
        len_next        = len_reg;
        addr_next       = addr_reg;
        type_next       = type_reg;
        sum_next        = sum_reg;
        cnt_next        = cnt_reg;
        bad_next        = bad_reg;
        done_next       = done_reg;
        res_status_next = res_status_reg;
        res_rdata_next  = res_rdata_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        stg_we          = 1'b0;
        stg_byte        = byte_val;
        rd_en           = 1'b0;
        creq.start      = 1'b0;
        creq.base       = addr_reg;
        creq.count      = 8'(cnt_reg);

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_WORK;
                end
            end

            S_WORK:
            begin
                res_status_next = ST_BUSY;
                res_rdata_next  = 8'd0;
                state_next      = S_SEND;
                if (act_reg)
                begin
                    // fetch the image byte; state untouched
                    rd_en      = 1'b1;
                    state_next = S_READ;
                end
                else if (done_reg)
                begin
                    res_status_next = ST_IGNORED;
                end
                else if (char_reg == CH_CR || char_reg == CH_LF)
                begin
                    if (phase_reg == PH_START)
                    begin
                        res_status_next = ST_IGNORED;
                    end
                    else if (bad_reg || phase_reg != PH_TRAIL || sum_reg != 8'd0)
                    begin
                        res_status_next = ST_ERROR;
                    end
                    else if (type_reg == 8'd0)
                    begin
                        creq.start      = 1'b1;
                        res_status_next = ST_COMMITTED;
                        state_next      = S_COMMIT;
                    end
                    else if (type_reg == 8'd1)
                    begin
                        done_next       = 1'b1;
                        res_status_next = ST_END;
                    end
                    else
                    begin
                        res_status_next = ST_OTHER;
                    end
                    // start a fresh line
                    phase_next     = PH_START;
                    nib_valid_next = 1'b0;
                    nib_val_next   = 4'd0;
                    len_next       = 8'd0;
                    addr_next      = 16'd0;
                    type_next      = 8'd0;
                    sum_next       = 8'd0;
                    cnt_next       = '0;
                    bad_next       = 1'b0;
                end
                else if (phase_reg == PH_START)
                begin
                    if (char_reg != CH_COLON)
                    begin
                        bad_next = 1'b1;
                    end
                    phase_next = PH_LEN;
                end
                else if (bad_reg || phase_reg == PH_TRAIL)
                begin
                    // skip until line end
                end
                else if (!hex[4])
                begin
                    bad_next = 1'b1;
                end
                else if (!nib_valid_reg)
                begin
                    nib_valid_next = 1'b1;
                    nib_val_next   = hex[3:0];
                end
                else
                begin
                    nib_valid_next = 1'b0;
                    nib_val_next   = 4'd0;
                    sum_next       = sum_reg + byte_val;
                    unique case (phase_reg)
                        PH_LEN:
                        begin
                            len_next = byte_val;
                            if ({1'b0, byte_val} >= 9'(MAX_RECORD))
                            begin
                                bad_next = 1'b1;
                            end
                            phase_next = PH_AHI;
                        end
                        PH_AHI:
                        begin
                            addr_next  = {byte_val, 8'd0};
                            phase_next = PH_ALO;
                        end
                        PH_ALO:
                        begin
                            addr_next  = {addr_reg[15:8], byte_val};
                            phase_next = PH_TYPE;
                        end
                        PH_TYPE:
                        begin
                            type_next  = byte_val;
                            phase_next = (len_reg == 8'd0) ? PH_SUM : PH_DATA;
                        end
                        PH_DATA:
                        begin
                            stg_we   = 1'b1;
                            cnt_next = cnt_reg + IDX_W'(1);
                            if (9'(cnt_reg) + 9'd1 >= {1'b0, len_reg})
                            begin
                                phase_next = PH_SUM;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_TRAIL;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                res_rdata_next = rd_data;
                state_next     = S_SEND;
            end

            S_COMMIT:
            begin
                if (cstat.done)
                begin
                    state_next = S_SEND;
                end
            end

            S_SEND:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    out_data_next = OUT_W'({byte_total, high_mark, low_mark, res_rdata_reg});
                    out_user_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_START;
            nib_valid_reg  <= 1'b0;
            nib_val_reg    <= 4'd0;
            len_reg        <= 8'd0;
            addr_reg       <= 16'd0;
            type_reg       <= 8'd0;
            sum_reg        <= 8'd0;
            cnt_reg        <= '0;
            bad_reg        <= 1'b0;
            done_reg       <= 1'b0;
            res_status_reg <= ST_BUSY;
            res_rdata_reg  <= 8'd0;
            m_valid_reg    <= 1'b0;
            out_data_reg   <= '0;
            out_user_reg   <= ST_BUSY;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            nib_valid_reg  <= nib_valid_next;
            nib_val_reg    <= nib_val_next;
            len_reg        <= len_next;
            addr_reg       <= addr_next;
            type_reg       <= type_next;
            sum_reg        <= sum_next;
            cnt_reg        <= cnt_next;
            bad_reg        <= bad_next;
            done_reg       <= done_next;
            res_status_reg <= res_status_next;
            res_rdata_reg  <= res_rdata_next;
            m_valid_reg    <= m_valid_next;
            out_data_reg   <= out_data_next;
            out_user_reg   <= out_user_next;
        end
    end

    // payload: held item
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= s_axis_tuser;
            char_reg  <= s_axis_tdata[7:0];
            raddr_reg <= s_axis_tdata[8 +: ADDR_BITS];
        end
    end

    // staging buffer: written by the parser, read by the commit unit
    always_ff @(posedge clk)
    begin
        if (stg_we)
        begin
            staged_mem[cnt_reg] <= stg_byte;
        end
        stg_rd_reg <= staged_mem[cstat.stage_idx[IDX_W-1:0]];
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

`default_nettype wire

[hw/rtl/ihex_checker.sv]
// Port-level checks for the Intel HEX image loader, bound to the top level.
`default_nettype none

module ihex_checker
    import ihex_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF,
    parameter int OUT_W     = ((2 * ADDR_BITS + 33 + 7) / 8) * 8
)
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             s_axis_tvalid,
    input wire logic             s_axis_tready,
    input wire logic             m_axis_tvalid,
    input wire logic             m_axis_tready,
    input wire logic [OUT_W-1:0] m_axis_tdata,
    input wire logic [2:0]       m_axis_tuser
);

    localparam int LOW_LSB   = 8;
    localparam int HIGH_LSB  = LOW_LSB + ADDR_BITS + 1;
    localparam int TOTAL_LSB = HIGH_LSB + ADDR_BITS;

    logic [7:0]           rd_field;
    logic [ADDR_BITS:0]   low_field;
    logic [ADDR_BITS-1:0] high_field;
    logic [23:0]          total_field;

    assign rd_field    = m_axis_tdata[7:0];
    assign low_field   = m_axis_tdata[LOW_LSB +: ADDR_BITS + 1];
    assign high_field  = m_axis_tdata[HIGH_LSB +: ADDR_BITS];
    assign total_field = m_axis_tdata[TOTAL_LSB +: 24];

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= ST_IGNORED))
        else $error("status code out of range");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_BUSY) |-> (rd_field == 8'd0))
        else $error("read data on a line result");

    a_marks_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (total_field != 24'd0) |-> ({1'b0, high_field} >= low_field))
        else $error("lowest address above highest address");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item taken while previous one in progress");

endmodule

bind intel_hex_image_loader ihex_checker #(
    .ADDR_BITS (ADDR_BITS)
) u_ihex_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the Intel HEX image loader: HEX text and image reads in, results checked.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    localparam int IN_W        = 24;
    localparam int OUT_W       = 72;
    localparam int ITEM_TARGET = 1400;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_WAIT  = 300;

    // Ways a generated line departs from a well-formed record
    typedef enum int {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_BAD_CHAR,
        FLAW_NO_COLON,
        FLAW_SHORT,
        FLAW_TAIL
    } line_flaw_e;

    // Receiver stall patterns
    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_PATTERN,
        RX_CHOKE
    } stall_mode_e;

    // Expected content of one result item
    typedef struct {
        status_t     st;
        logic [7:0]  rd;
        logic [16:0] lo;
        logic [15:0] hi;
        logic [23:0] total;
    } loader_result_t;

    // Line parser, image and marks, predicted alongside the block
    class ihex_scoreboard;
        typedef enum int {
            L_START, L_COUNT, L_ADDR_HI, L_ADDR_LO, L_KIND, L_DATA, L_CHECK, L_TAIL
        } line_step_e;

        line_step_e     step;
        bit             have_nibble;
        logic [3:0]     held_nibble;
        logic [7:0]     rec_len;
        logic [15:0]    rec_addr;
        logic [7:0]     rec_kind;
        logic [7:0]     sum;
        int             staged_count;
        bit             bad;
        logic [7:0]     staged [0:255];
        logic [7:0]     image [0:65535];
        bit             written [0:65535];
        int unsigned    written_list[$];
        logic [16:0]    low_mark;
        logic [15:0]    high_mark;
        logic [23:0]    total;
        bit             file_done;
        loader_result_t expected_q[$];
        int             fails;
        int             checked;
        int             reads;
        int             status_count [0:7];

        function new();
            clear_line();
            low_mark  = 17'h10000;
            high_mark = '0;
            total     = '0;
            file_done = 0;
            fails     = 0;
            checked   = 0;
            reads     = 0;
            foreach (status_count[i]) status_count[i] = 0;
        endfunction

        static function int nibble_of(logic [7:0] c);
            if (c >= "0" && c <= "9") return int'(c) - 48;
            if (c >= "A" && c <= "F") return int'(c) - 55;
            if (c >= "a" && c <= "f") return int'(c) - 87;
            return -1;
        endfunction

        function void clear_line();
            step         = L_START;
            have_nibble  = 0;
            held_nibble  = '0;
            rec_len      = '0;
            rec_addr     = '0;
            rec_kind     = '0;
            sum          = '0;
            staged_count = 0;
            bad          = 0;
        endfunction

        function void take_byte(logic [7:0] b);
            sum = sum + b;
            case (step)
                L_COUNT:
                begin
                    rec_len = b;
                    step    = L_ADDR_HI;
                end
                L_ADDR_HI:
                begin
                    rec_addr[15:8] = b;
                    step           = L_ADDR_LO;
                end
                L_ADDR_LO:
                begin
                    rec_addr[7:0] = b;
                    step          = L_KIND;
                end
                L_KIND:
                begin
                    rec_kind = b;
                    step     = (rec_len == 0) ? L_CHECK : L_DATA;
                end
                L_DATA:
                begin
                    staged[staged_count] = b;
                    staged_count++;
                    if (staged_count >= int'(rec_len)) step = L_CHECK;
                end
                default: step = L_TAIL;
            endcase
        endfunction

        // write staged bytes at consecutive wrapping addresses
        function void commit();
            logic [15:0] a;
            for (int i = 0; i < staged_count; i++)
            begin
                a = rec_addr + 16'(i);
                image[a] = staged[i];
                if (!written[a]) written_list.push_back(a);
                written[a] = 1;
                if ({1'b0, a} < low_mark) low_mark = {1'b0, a};
                if (a > high_mark) high_mark = a;
                if (total != TOTAL_MAX) total++;
            end
        endfunction

        function status_t close_line();
            status_t st;
            if (step == L_START) return ST_IGNORED;
            if (bad || step != L_TAIL || sum != 0)
                st = ST_ERROR;
            else if (rec_kind == 8'd0)
            begin
                commit();
                st = ST_COMMITTED;
            end
            else if (rec_kind == 8'd1)
            begin
                file_done = 1;
                st = ST_END;
            end
            else
                st = ST_OTHER;
            clear_line();
            return st;
        endfunction

        function status_t take_text(logic [7:0] c);
            int v;
            if (file_done) return ST_IGNORED;
            if (c == CH_CR || c == CH_LF) return close_line();
            if (step == L_START)
            begin
                if (c != CH_COLON) bad = 1;
                step = L_COUNT;
                return ST_BUSY;
            end
            if (bad || step == L_TAIL) return ST_BUSY;
            v = nibble_of(c);
            if (v < 0)
            begin
                bad = 1;
                return ST_BUSY;
            end
            if (have_nibble)
            begin
                have_nibble = 0;
                take_byte({held_nibble, 4'(v)});
            end
            else
            begin
                have_nibble = 1;
                held_nibble = 4'(v);
            end
            return ST_BUSY;
        endfunction

        // note an accepted input item and queue the result it should give
        function void note_input(bit is_read, logic [7:0] ch, logic [15:0] addr);
            loader_result_t r;
            r.rd = '0;
            if (is_read)
            begin
                r.st = ST_BUSY;
                r.rd = image[addr];
                reads++;
            end
            else
            begin
                r.st = take_text(ch);
                status_count[r.st]++;
            end
            r.lo    = low_mark;
            r.hi    = high_mark;
            r.total = total;
            expected_q.push_back(r);
        endfunction

        function void report(string field, logic [23:0] want_v, logic [23:0] got_v);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want_v, got_v);
            fails++;
        endfunction

        // compare one accepted result item with the oldest expectation
        function void check_result(logic [2:0] st, logic [OUT_W-1:0] d);
            loader_result_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, status %h data %h", $time, st, d);
                fails++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (st !== want.st) report("status", 24'(want.st), 24'(st));
            if (d[7:0] !== want.rd) report("read_data", 24'(want.rd), 24'(d[7:0]));
            if (d[24:8] !== want.lo) report("lowest_address", 24'(want.lo), 24'(d[24:8]));
            if (d[40:25] !== want.hi) report("highest_address", 24'(want.hi), 24'(d[40:25]));
            if (d[64:41] !== want.total) report("bytes_loaded", want.total, d[64:41]);
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [IN_W-1:0]  s_axis_tdata;    // text_char, read_address
    logic             s_axis_tuser;    // action
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;    // read_data, lowest_address, highest_address, bytes_loaded
    logic [2:0]       m_axis_tuser;    // status

    ihex_scoreboard sb;
    int             items_sent;
    int             burst_left;
    bit             steady;
    int             cycles;

    intel_hex_image_loader u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hold every input at a known value from time zero
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
    end

    // Receiver: switch between open, coin-toss, fixed pattern and choked stretches
    initial
    begin
        stall_mode_e mode;
        int          span;
        int          k;
        k = 0;
        forever
        begin
            mode = stall_mode_e'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                k++;
                case (mode)
                    RX_OPEN:    m_axis_tready <= 1'b1;
                    RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: m_axis_tready <= ((k % 7) < 3);
                    default:    m_axis_tready <= ((k % 23) == 0);
                endcase
            end
        end
    end

    // Check every result item the block hands over
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
        if (n < 4'd10) return 8'(n) + "0";
        return 8'(n) - 8'd10 + (lower ? "a" : "A");
    endfunction

    // Draw a character that never ends a line; optionally no hex digit, or no colon
    function automatic logic [7:0] pick_junk(bit non_hex, bit no_colon);
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == CH_CR || c == CH_LF || (no_colon && c == CH_COLON)
               || (non_hex && ihex_scoreboard::nibble_of(c) >= 0));
        return c;
    endfunction

    // Idle between bursts; some stretches run with no gaps at all
    task automatic pause_after_item();
        int gap;
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(1, 24);
        if ($urandom_range(0, 9) == 0) steady = !steady;
        gap = steady ? 0 : $urandom_range(1, 7);
        if (gap == 0) return;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= IN_W'($urandom);
        repeat (gap) @(posedge clk);
    endtask

    // Offer one item, hold it until accepted, then note it
    task automatic send_item(bit is_read, logic [7:0] ch, logic [15:0] addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= is_read;
        s_axis_tdata  <= {addr, ch};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_input(is_read, ch, addr);
        items_sent++;
        pause_after_item();
    endtask

    // Read back a byte that some committed record has written
    task automatic send_read();
        int unsigned a;
        if (sb.written_list.size() == 0) return;
        a = sb.written_list[$urandom_range(0, sb.written_list.size() - 1)];
        send_item(1'b1, 8'($urandom), 16'(a));
    endtask

    // Send a text character, now and then preceded by an image read
    task automatic send_text(logic [7:0] ch);
        if ($urandom_range(0, 15) == 0) send_read();
        send_item(1'b0, ch, 16'($urandom));
    endtask

    task automatic send_line_end();
        case ($urandom_range(0, 2))
            0: send_text(CH_CR);
            1: send_text(CH_LF);
            default:
            begin
                send_text(CH_CR);
                send_text(CH_LF);
            end
        endcase
    endtask

    // Build one record as text, spoil it as asked, send it and end the line.
    // casing: 0 upper, 1 lower, 2 mixed per digit.
    task automatic send_record(int len, logic [15:0] addr, logic [7:0] kind,
                               line_flaw_e flaw, int casing);
        logic [7:0] bytes[$];
        logic [7:0] text[$];
        logic [7:0] total;
        int         cut;
        bit         lower;
        bytes.push_back(8'(len));
        bytes.push_back(addr[15:8]);
        bytes.push_back(addr[7:0]);
        bytes.push_back(kind);
        repeat (len) bytes.push_back(8'($urandom));
        total = '0;
        foreach (bytes[i]) total += bytes[i];
        bytes.push_back(8'd0 - total);
        if (flaw == FLAW_SUM) bytes[bytes.size() - 1] += 8'($urandom_range(1, 255));

        text.push_back(flaw == FLAW_NO_COLON ? pick_junk(1'b0, 1'b1) : CH_COLON);
        foreach (bytes[i])
        begin
            lower = (casing == 2) ? 1'($urandom_range(0, 1)) : 1'(casing);
            text.push_back(hex_char(bytes[i][7:4], lower));
            lower = (casing == 2) ? 1'($urandom_range(0, 1)) : 1'(casing);
            text.push_back(hex_char(bytes[i][3:0], lower));
        end

        case (flaw)
            // land the stray character after the first character and before the last checksum digit
            FLAW_BAD_CHAR:
                text.insert($urandom_range(1, text.size() - 1), pick_junk(1'b1, 1'b0));
            FLAW_SHORT:
            begin
                cut  = $urandom_range(1, text.size() - 1);
                text = text[0:cut-1];
            end
            FLAW_TAIL:
                repeat ($urandom_range(1, 6)) text.push_back(pick_junk(1'b0, 1'b0));
            default: ;
        endcase

        foreach (text[i]) send_text(text[i]);
        send_line_end();
    endtask

    function automatic int pick_len();
        int t;
        t = $urandom_range(0, 99);
        if (t < 70) return $urandom_range(0, 8);
        if (t < 98) return $urandom_range(9, 40);
        return $urandom_range(200, 255);
    endfunction

    function automatic logic [15:0] pick_addr(int len);
        if ($urandom_range(0, 4) == 0) return 16'hFFFF - 16'($urandom_range(0, len + 2));
        return 16'($urandom);
    endfunction

    initial
    begin
        int         r;
        int         len;
        line_flaw_e flaw;
        sb         = new();
        items_sent = 0;
        burst_left = 0;
        steady     = 0;
        cycles     = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: empty line, wrapping data record in lower case, reads at both
        // ends of the image, bad first character, stray character, short line, and
        // another record type with trailing text
        send_text(CH_LF);
        send_record(2, 16'hFFFF, 8'd0, FLAW_NONE, 1);
        send_item(1'b1, 8'hFF, 16'hFFFF);
        send_item(1'b1, 8'h00, 16'h0000);
        send_text(8'hFF);
        send_text(CH_CR);
        send_text(CH_COLON);
        send_text("0");
        send_text(8'h80);
        send_text(CH_LF);
        send_record(1, 16'h1234, 8'd0, FLAW_SHORT, 0);
        send_record(0, 16'h0000, 8'd5, FLAW_TAIL, 0);

        // Random: well-formed records with random content, mixed with flawed lines, line ends and image reads
        send_record(255, 16'($urandom), 8'd0, FLAW_NONE, 2);
        while (items_sent < ITEM_TARGET)
        begin
            r   = $urandom_range(0, 99);
            len = pick_len();
            flaw = ($urandom_range(0, 4) == 0) ? FLAW_TAIL : FLAW_NONE;
            if (r < 45)
                send_record(len, pick_addr(len), 8'd0, flaw, $urandom_range(0, 2));
            else if (r < 55)
                send_record(len, pick_addr(len), 8'($urandom_range(2, 255)), flaw,
                            $urandom_range(0, 2));
            else if (r < 63)
                send_record(len, pick_addr(len), 8'($urandom_range(0, 3)), FLAW_SUM,
                            $urandom_range(0, 2));
            else if (r < 70)
                send_record(len, pick_addr(len), 8'($urandom_range(0, 1)), FLAW_BAD_CHAR,
                            $urandom_range(0, 2));
            else if (r < 74)
                send_record(len, pick_addr(len), 8'($urandom_range(0, 1)), FLAW_NO_COLON,
                            $urandom_range(0, 2));
            else if (r < 81)
                send_record(len, pick_addr(len), 8'($urandom_range(0, 1)), FLAW_SHORT,
                            $urandom_range(0, 2));
            else if (r < 87)
                send_text($urandom_range(0, 1) ? CH_CR : CH_LF);
            else
                repeat ($urandom_range(1, 6)) send_read();
        end

        // End of file record, then text that must be ignored and a few last reads
        send_record($urandom_range(0, 3), 16'($urandom), 8'd1, FLAW_NONE, 2);
        repeat (12) send_text($urandom_range(0, 3) == 0 ? CH_COLON : 8'($urandom));
        send_text(CH_LF);
        repeat (10) send_read();
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding results, then watch for strays
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Covered %0d items (%0d image reads); %0d results checked, %0d mismatches.",
                 items_sent, sb.reads, sb.checked, sb.fails);
        $display("Lines: %0d committed, %0d end, %0d error, %0d other type, %0d ignored chars; %0d bytes loaded.",
                 sb.status_count[ST_COMMITTED], sb.status_count[ST_END],
                 sb.status_count[ST_ERROR], sb.status_count[ST_OTHER],
                 sb.status_count[ST_IGNORED], sb.total);
        if (sb.fails == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[intel_hex_image_loader.f]
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_commit.sv
hw/rtl/intel_hex_image_loader.sv
hw/rtl/ihex_checker.sv
test/tb.sv
